[sv/acpt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the affine chain point transform.
// No dependencies; imported by the top level.
package acpt_pkg;

   localparam int COORD_BITS_DEFAULT = 10;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_X  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_Y  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_Z  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SECOND_X = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SECOND_Y = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SECOND_Z = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_CROP     = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROT      = 3'd7;

   // One affine row: Q4.12 coefficients and a Q12.4 translation.
   typedef struct packed {
      logic signed [15:0] t;
      logic signed [15:0] c2;
      logic signed [15:0] c1;
      logic signed [15:0] c0;
   } affine_row_type;

   localparam affine_row_type ROW_X_RESET = affine_row_type'(64'h0000_0000_0000_1000);
   localparam affine_row_type ROW_Y_RESET = affine_row_type'(64'h0000_0000_1000_0000);
   localparam affine_row_type ROW_Z_RESET = affine_row_type'(64'h0000_1000_0000_0000);

   localparam logic signed [15:0] COS_RESET = 16'sd16384;
   localparam logic signed [15:0] SIN_RESET = 16'sd0;

   localparam int CENTER = 100;

   // Fractional bits at each rounding point.
   localparam int Q_SECOND = 12;
   localparam int Q_ROT    = 26;

   // Translation plus crop, brought to Q.24, with the rounding half and the
   // rotation center folded in.
   localparam int BIAS_W = 39;
   localparam logic signed [BIAS_W-1:0] BIAS_K =
      BIAS_W'(64'sd1 <<< (Q_SECOND - 1)) - BIAS_W'(64'sd100 <<< (2 * Q_SECOND));

   localparam logic signed [63:0] ROT_K =
      (64'sd100 <<< Q_ROT) + (64'sd1 <<< (Q_ROT - 1));

   localparam int OUT_MAX = 32767;
   localparam int OUT_MIN = -32768;

endpackage

[sv/affine_chain_point_transform_top.sv]
`timescale 1ns / 1ps
// Top level of the affine chain point transform: six-stage multiply-add pipeline.
// Depends on acpt_pkg for register layout, codes and constants.

// Maps pixel coordinates through two affine rows sets, a crop offset and a Z
// rotation about (100,100), returning rounded, saturated 16-bit x and y. One
// point enters per cycle unless every stage is full and the output stalls. The
// pipeline stages, in order: first map products, first map sums, second map
// products, second map sums, rotation products, rotation sums with saturation.
// A stage holds its beat while the next one is full and cannot move on, so empty
// stages keep accepting points while a result waits. The user must ensure
// registers are written only while no point is in flight; the block does not enforce it.
module affine_chain_point_transform_top
   import acpt_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: in_x, in_y, zero padding.
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: out_x, out_y.
   output logic [31:0]                         rsp_tdata,
   // Fields from bit 0: clipped.
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [CSR_ADDR_W-1:0]               csr_addr,
   input  logic [CSR_DATA_W-1:0]               csr_wdata
);

   localparam int NSTG    = 6;
   localparam int P1_W    = COORD_BITS + 17;
   localparam int AW      = COORD_BITS + 19;
   localparam int P2_W    = AW + 16;
   localparam int BSUM_W  = COORD_BITS + 37;
   localparam int BW      = BSUM_W - Q_SECOND;
   localparam int P3_W    = BW + 16;
   localparam int RW      = COORD_BITS + 43;
   localparam int RS_W    = RW - Q_ROT;

   localparam logic signed [RS_W-1:0] SAT_MAX = RS_W'(OUT_MAX);
   localparam logic signed [RS_W-1:0] SAT_MIN = RS_W'(OUT_MIN);
   localparam logic signed [RW-1:0]   ROT_BIAS = RW'(ROT_K);

   // Configuration registers.
   affine_row_type    first_row_x_ff, first_row_y_ff, first_row_z_ff;
   affine_row_type    second_row_x_ff, second_row_y_ff;
   logic signed [15:0] crop_x_ff, crop_y_ff;
   logic signed [15:0] cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_row_x_ff  <= ROW_X_RESET;
         first_row_y_ff  <= ROW_Y_RESET;
         first_row_z_ff  <= ROW_Z_RESET;
         second_row_x_ff <= ROW_X_RESET;
         second_row_y_ff <= ROW_Y_RESET;
         crop_x_ff       <= 16'sd0;
         crop_y_ff       <= 16'sd0;
         cos_ff          <= COS_RESET;
         sin_ff          <= SIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_FIRST_X:  first_row_x_ff  <= affine_row_type'(csr_wdata);
            CSR_FIRST_Y:  first_row_y_ff  <= affine_row_type'(csr_wdata);
            CSR_FIRST_Z:  first_row_z_ff  <= affine_row_type'(csr_wdata);
            CSR_SECOND_X: second_row_x_ff <= affine_row_type'(csr_wdata);
            CSR_SECOND_Y: second_row_y_ff <= affine_row_type'(csr_wdata);
            // The z row of the second map feeds nothing downstream.
            CSR_SECOND_Z: ;
            CSR_CROP: begin
               crop_x_ff <= csr_wdata[15:0];
               crop_y_ff <= csr_wdata[31:16];
            end
            CSR_ROT: begin
               cos_ff <= csr_wdata[15:0];
               sin_ff <= csr_wdata[31:16];
            end
            default: ;
         endcase
      end
   end

   // Stage handshake: a stage loads when it is empty or its beat moves on.
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] adv;

   always_comb begin
      adv[NSTG-1] = !valid_ff[NSTG-1] || rsp_tready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_tready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Stage 1: first map products. The z input is zero, so c2 drops out.
   logic signed [COORD_BITS:0] xs, ys;
   logic signed [P1_W-1:0] s1_xx_ff, s1_xy_ff, s1_yx_ff, s1_yy_ff, s1_zx_ff, s1_zy_ff;
   logic signed [P1_W-1:0] s1_xx_in, s1_xy_in, s1_yx_in, s1_yy_in, s1_zx_in, s1_zy_in;

   assign xs = $signed({1'b0, req_tdata[COORD_BITS-1:0]});
   assign ys = $signed({1'b0, req_tdata[2*COORD_BITS-1:COORD_BITS]});

   always_comb begin
      s1_xx_in = P1_W'(xs * first_row_x_ff.c0);
      s1_xy_in = P1_W'(ys * first_row_x_ff.c1);
      s1_yx_in = P1_W'(xs * first_row_y_ff.c0);
      s1_yy_in = P1_W'(ys * first_row_y_ff.c1);
      s1_zx_in = P1_W'(xs * first_row_z_ff.c0);
      s1_zy_in = P1_W'(ys * first_row_z_ff.c1);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_xx_ff <= s1_xx_in;
         s1_xy_ff <= s1_xy_in;
         s1_yx_ff <= s1_yx_in;
         s1_yy_ff <= s1_yy_in;
         s1_zx_ff <= s1_zx_in;
         s1_zy_ff <= s1_zy_in;
      end
   end

   // Stage 2: first map sums in Q.12, exact.
   logic signed [AW-1:0] s2_ax_ff, s2_ay_ff, s2_az_ff;
   logic signed [AW-1:0] s2_ax_in, s2_ay_in, s2_az_in;

   always_comb begin
      s2_ax_in = AW'(s1_xx_ff) + AW'(s1_xy_ff) + AW'($signed({first_row_x_ff.t, 8'd0}));
      s2_ay_in = AW'(s1_yx_ff) + AW'(s1_yy_ff) + AW'($signed({first_row_y_ff.t, 8'd0}));
      s2_az_in = AW'(s1_zx_ff) + AW'(s1_zy_ff) + AW'($signed({first_row_z_ff.t, 8'd0}));
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_ax_ff <= s2_ax_in;
         s2_ay_ff <= s2_ay_in;
         s2_az_ff <= s2_az_in;
      end
   end

   // Stage 3: second map products and the constant part of each row.
   logic signed [P2_W-1:0] s3_x0_ff, s3_x1_ff, s3_x2_ff, s3_y0_ff, s3_y1_ff, s3_y2_ff;
   logic signed [P2_W-1:0] s3_x0_in, s3_x1_in, s3_x2_in, s3_y0_in, s3_y1_in, s3_y2_in;
   logic signed [BIAS_W-1:0] s3_bias_x_ff, s3_bias_y_ff;
   logic signed [BIAS_W-1:0] s3_bias_x_in, s3_bias_y_in;

   always_comb begin
      s3_x0_in = P2_W'(s2_ax_ff * second_row_x_ff.c0);
      s3_x1_in = P2_W'(s2_ay_ff * second_row_x_ff.c1);
      s3_x2_in = P2_W'(s2_az_ff * second_row_x_ff.c2);
      s3_y0_in = P2_W'(s2_ax_ff * second_row_y_ff.c0);
      s3_y1_in = P2_W'(s2_ay_ff * second_row_y_ff.c1);
      s3_y2_in = P2_W'(s2_az_ff * second_row_y_ff.c2);
      s3_bias_x_in = ((BIAS_W'(second_row_x_ff.t) + BIAS_W'(crop_x_ff)) <<< 20) + BIAS_K;
      s3_bias_y_in = ((BIAS_W'(second_row_y_ff.t) + BIAS_W'(crop_y_ff)) <<< 20) + BIAS_K;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_x0_ff     <= s3_x0_in;
         s3_x1_ff     <= s3_x1_in;
         s3_x2_ff     <= s3_x2_in;
         s3_y0_ff     <= s3_y0_in;
         s3_y1_ff     <= s3_y1_in;
         s3_y2_ff     <= s3_y2_in;
         s3_bias_x_ff <= s3_bias_x_in;
         s3_bias_y_ff <= s3_bias_y_in;
      end
   end

   // Stage 4: second map sums, rounded to Q.12, already relative to the center.
   logic signed [BSUM_W-1:0] bsum_x, bsum_y;
   logic signed [BW-1:0] s4_bx_ff, s4_by_ff;
   logic signed [BW-1:0] s4_bx_in, s4_by_in;

   always_comb begin
      bsum_x = BSUM_W'(s3_x0_ff) + BSUM_W'(s3_x1_ff) + BSUM_W'(s3_x2_ff)
             + BSUM_W'(s3_bias_x_ff);
      bsum_y = BSUM_W'(s3_y0_ff) + BSUM_W'(s3_y1_ff) + BSUM_W'(s3_y2_ff)
             + BSUM_W'(s3_bias_y_ff);
      s4_bx_in = bsum_x[BSUM_W-1:Q_SECOND];
      s4_by_in = bsum_y[BSUM_W-1:Q_SECOND];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_bx_ff <= s4_bx_in;
         s4_by_ff <= s4_by_in;
      end
   end

   // Stage 5: rotation products in Q.26.
   logic signed [P3_W-1:0] s5_xc_ff, s5_ys_ff, s5_xs_ff, s5_yc_ff;
   logic signed [P3_W-1:0] s5_xc_in, s5_ys_in, s5_xs_in, s5_yc_in;

   always_comb begin
      s5_xc_in = P3_W'(s4_bx_ff * cos_ff);
      s5_ys_in = P3_W'(s4_by_ff * sin_ff);
      s5_xs_in = P3_W'(s4_bx_ff * sin_ff);
      s5_yc_in = P3_W'(s4_by_ff * cos_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_xc_ff <= s5_xc_in;
         s5_ys_ff <= s5_ys_in;
         s5_xs_ff <= s5_xs_in;
         s5_yc_ff <= s5_yc_in;
      end
   end

   // Stage 6: rotation sums, round to integer with ties upward, saturate.
   logic signed [RW-1:0]   rsum_x, rsum_y;
   logic signed [RS_W-1:0] rint_x, rint_y;
   logic                   clip_x, clip_y;
   logic [15:0]            s6_x_ff, s6_y_ff, s6_x_in, s6_y_in;
   logic                   s6_clip_ff, s6_clip_in;

   always_comb begin
      rsum_x = RW'(s5_xc_ff) - RW'(s5_ys_ff) + ROT_BIAS;
      rsum_y = RW'(s5_xs_ff) + RW'(s5_yc_ff) + ROT_BIAS;
      rint_x = rsum_x[RW-1:Q_ROT];
      rint_y = rsum_y[RW-1:Q_ROT];
      clip_x = (rint_x > SAT_MAX) || (rint_x < SAT_MIN);
      clip_y = (rint_y > SAT_MAX) || (rint_y < SAT_MIN);
      if (rint_x > SAT_MAX) begin
         s6_x_in = SAT_MAX[15:0];
      end else if (rint_x < SAT_MIN) begin
         s6_x_in = SAT_MIN[15:0];
      end else begin
         s6_x_in = rint_x[15:0];
      end
      if (rint_y > SAT_MAX) begin
         s6_y_in = SAT_MAX[15:0];
      end else if (rint_y < SAT_MIN) begin
         s6_y_in = SAT_MIN[15:0];
      end else begin
         s6_y_in = rint_y[15:0];
      end
      s6_clip_in = clip_x || clip_y;
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_x_ff    <= s6_x_in;
         s6_y_ff    <= s6_y_in;
         s6_clip_ff <= s6_clip_in;
      end
   end

   assign rsp_tvalid   = valid_ff[NSTG-1];
   assign rsp_tdata    = {s6_y_ff, s6_x_ff};
   assign rsp_tuser[0] = s6_clip_ff;

`ifndef ASSERT_OFF
   // A full pipeline with a stalled output must not take another beat.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_tready |-> !req_tready)
      else $error("input accepted while every stage is full and stalled");

   // An accepted beat always lands in the first stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted beat did not enter the first stage");

   // Clipping is only flagged when an output sits at a rail.
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[15:0] == 16'h7fff) || (rsp_tdata[15:0] == 16'h8000) ||
         (rsp_tdata[31:16] == 16'h7fff) || (rsp_tdata[31:16] == 16'h8000))
      else $error("clip flag set with both outputs inside range");
`endif

endmodule
